[sv/lru_pkg.sv]
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants, width helpers and the link and update types that pass
// between the frame cells and the top level.
// ----------------------------------------------------------------------------
package lru_pkg;

    // Fixed field widths of the block's ports.
    localparam int PAGE_IN_W = 10;
    localparam int FIDX_W    = 3;
    localparam int FAULT_W   = 32;
    localparam int CFG_W     = 4;

    // Default sizing.
    localparam int NUM_FRAMES_DEF = 8;
    localparam int PAGE_COUNT_DEF = 1024;

    // Reset value of the frames-in-use register.
    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;

    // Control flags that travel with a search word along the cell chain.
    typedef struct packed {
        logic valid;
        logic hit_found;
        logic empty_found;
    } lru_link_t;

    // Update command broadcast to all cells when a search completes.
    typedef struct packed {
        logic valid;
        logic miss;
    } lru_cmd_t;

    // Bits needed to index n frames (at least one).
    function automatic int lru_idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Bits needed to hold a count from 0 to n.
    function automatic int lru_cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

    // Bits of a page number once reduced modulo the page count.
    function automatic int lru_page_w(input int pc);
        return (pc >= (2 ** PAGE_IN_W)) ? PAGE_IN_W : $clog2(pc);
    endfunction

endpackage

[sv/lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Looks up one page reference at a time among a row of frame cells, updates
// the recency ranks and reports hit, frame, eviction and fault total.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive page_number and raise start; the word is taken at a clock
//   edge where start is high and busy is low. busy then stays high until the
//   lookup has been committed.
//   Output: the result is shown on hit, frame_index, evicted_valid,
//   evicted_page and fault_total for exactly one cycle while done is high.
//   The receiver must take it then; there is no way to hold it off.
//   Configuration: frames_in_use is written through cfg_valid / cfg_ready /
//   cfg_data while busy is low; values of zero act as one, values above
//   NUM_FRAMES act as NUM_FRAMES.
//   Timing: after the accepting edge the word passes the page reduction
//   stages, then each frame cell in turn as the search word walks the chain
//   (the first cell works on the second stage's output), and then the
//   commit register that raises done. A new word can be taken in the cycle
//   done is high; no new word is taken while one is still in flight.
//   Reset: all frames empty, ranks and fault total zero, frames_in_use 8.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lru_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Command channel.
    input  logic                   start,
    output logic                   busy,
    input  logic [PAGE_IN_W-1:0]   page_number,
    // Result channel.
    output logic                   done,
    output logic                   hit,
    output logic [FIDX_W-1:0]      frame_index,
    output logic                   evicted_valid,
    output logic [PAGE_IN_W-1:0]   evicted_page,
    output logic [FAULT_W-1:0]     fault_total,
    // Configuration channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int IW = lru_idx_w(NUM_FRAMES);
    localparam int CW = lru_cnt_w(NUM_FRAMES);
    localparam int PW = lru_page_w(PAGE_COUNT);

    logic                 busy_reg;
    logic                 busy_next;
    logic [CFG_W-1:0]     cfg_frames_reg;
    logic [CW-1:0]        active_count;
    logic [FAULT_W-1:0]   fault_count_reg;
    logic [FAULT_W-1:0]   fault_count_next;

    logic                 accept;
    logic                 mod_valid;
    logic [PW-1:0]        mod_page;

    // Chain links; entry i feeds cell i.
    lru_link_t            ch_link      [NUM_FRAMES+1];
    logic [PW-1:0]        ch_page      [NUM_FRAMES+1];
    logic [IW-1:0]        ch_hit_idx   [NUM_FRAMES+1];
    logic [IW-1:0]        ch_hit_rank  [NUM_FRAMES+1];
    logic [IW-1:0]        ch_empty_idx [NUM_FRAMES+1];
    logic [IW-1:0]        ch_best_rank [NUM_FRAMES+1];
    logic [IW-1:0]        ch_best_idx  [NUM_FRAMES+1];
    logic [PW-1:0]        ch_best_page [NUM_FRAMES+1];

    lru_link_t            last;
    lru_cmd_t             cmd;
    logic [IW-1:0]        cmd_target;
    logic                 evict;

    logic                 done_reg;
    logic                 hit_reg;
    logic [FIDX_W-1:0]    frame_index_reg;
    logic                 evicted_valid_reg;
    logic [PAGE_IN_W-1:0] evicted_page_reg;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_frames_reg <= CFG_FRAMES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_frames_reg <= cfg_data;
        end
    end

    // Clamp the frame count to the built range.
    always_comb
    begin
        if (cfg_frames_reg == '0)
        begin
            active_count = CW'(1);
        end
        else if (int'(cfg_frames_reg) > NUM_FRAMES)
        begin
            active_count = CW'(NUM_FRAMES);
        end
        else
        begin
            active_count = CW'(cfg_frames_reg);
        end
    end

    // Page reduction ahead of the chain.
    lru_page_mod #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_page_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_page   (page_number),
        .out_valid (mod_valid),
        .out_page  (mod_page)
    );

    // Seed word entering the first cell.
    always_comb
    begin
        ch_link[0].valid       = mod_valid;
        ch_link[0].hit_found   = 1'b0;
        ch_link[0].empty_found = 1'b0;
        ch_page[0]             = mod_page;
        ch_hit_idx[0]          = '0;
        ch_hit_rank[0]         = '0;
        ch_empty_idx[0]        = '0;
        ch_best_rank[0]        = '0;
        ch_best_idx[0]         = '0;
        ch_best_page[0]        = '0;
    end

    // Row of frame cells.
    generate
        for (genvar i = 0; i < NUM_FRAMES; i++)
        begin : g_cell
            lru_cell #(
                .NUM_FRAMES (NUM_FRAMES),
                .PAGE_COUNT (PAGE_COUNT),
                .CELL_ID    (i)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .active_count  (active_count),
                .in_link       (ch_link[i]),
                .in_page       (ch_page[i]),
                .in_hit_idx    (ch_hit_idx[i]),
                .in_hit_rank   (ch_hit_rank[i]),
                .in_empty_idx  (ch_empty_idx[i]),
                .in_best_rank  (ch_best_rank[i]),
                .in_best_idx   (ch_best_idx[i]),
                .in_best_page  (ch_best_page[i]),
                .out_link      (ch_link[i+1]),
                .out_page      (ch_page[i+1]),
                .out_hit_idx   (ch_hit_idx[i+1]),
                .out_hit_rank  (ch_hit_rank[i+1]),
                .out_empty_idx (ch_empty_idx[i+1]),
                .out_best_rank (ch_best_rank[i+1]),
                .out_best_idx  (ch_best_idx[i+1]),
                .out_best_page (ch_best_page[i+1]),
                .cmd           (cmd),
                .cmd_target    (cmd_target),
                .cmd_limit     (ch_hit_rank[NUM_FRAMES]),
                .cmd_page      (ch_page[NUM_FRAMES])
            );
        end
    endgenerate

    // Decision from the completed search word.
    always_comb
    begin
        last      = ch_link[NUM_FRAMES];
        cmd.valid = last.valid;
        cmd.miss  = !last.hit_found;
        evict     = !last.hit_found && !last.empty_found;
        if (last.hit_found)
        begin
            cmd_target = ch_hit_idx[NUM_FRAMES];
        end
        else if (last.empty_found)
        begin
            cmd_target = ch_empty_idx[NUM_FRAMES];
        end
        else
        begin
            cmd_target = ch_best_idx[NUM_FRAMES];
        end
    end

    // Saturating fault counter.
    always_comb
    begin
        fault_count_next = fault_count_reg;
        if (cmd.valid && cmd.miss && (fault_count_reg != '1))
        begin
            fault_count_next = fault_count_reg + 1'b1;
        end
    end

    // Busy from acceptance until the commit cycle.
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (cmd.valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            fault_count_reg <= '0;
        end
        else
        begin
            busy_reg        <= busy_next;
            done_reg        <= cmd.valid;
            fault_count_reg <= fault_count_next;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (cmd.valid)
        begin
            hit_reg           <= last.hit_found;
            frame_index_reg   <= FIDX_W'(cmd_target);
            evicted_valid_reg <= evict;
            evicted_page_reg  <= evict ? PAGE_IN_W'(ch_best_page[NUM_FRAMES]) : '0;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_count_reg;

    // A result is shown only once the block is free again.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result shown while a lookup is still running");

    // A resident page never evicts anything.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> !evicted_valid_reg)
        else $error("eviction reported on a hit");

    // The fault total moves only together with a result.
    a_fault_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fault_count_reg) |-> done_reg)
        else $error("fault total changed outside a commit");

    // At most one search word is in the chain at any time.
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0({mod_valid, last.valid, ch_link[1].valid}))
        else $error("more than one search word in flight");

    // A new word is taken only when the block was idle.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && !done_reg))
        else $error("acceptance did not start a lookup");

endmodule

[sv/lru_page_mod.sv]
// ----------------------------------------------------------------------------
// LRU page number reduction
// Two-stage reduction of the incoming page number modulo the page count,
// using a reciprocal multiply followed by a back-multiply and correction.
// ----------------------------------------------------------------------------
module lru_page_mod
    import lru_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [PAGE_IN_W-1:0]                in_page,
    output logic                                out_valid,
    output logic [lru_page_w(PAGE_COUNT)-1:0]   out_page
);

    localparam int PW = lru_page_w(PAGE_COUNT);

    logic stage1_valid_reg;
    logic stage2_valid_reg;

    // Valid bits of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_valid_reg <= 1'b0;
            stage2_valid_reg <= 1'b0;
        end
        else
        begin
            stage1_valid_reg <= in_valid;
            stage2_valid_reg <= stage1_valid_reg;
        end
    end

    assign out_valid = stage2_valid_reg;

    generate
        if (PAGE_COUNT >= (2 ** PAGE_IN_W))
        begin : g_no_reduce
            // Every input page is already below the page count.
            logic [PAGE_IN_W-1:0] page_reg;
            logic [PW-1:0]        rem_reg;

            always_ff @(posedge clk)
            begin
                page_reg <= in_page;
                rem_reg  <= PW'(page_reg);
            end

            assign out_page = rem_reg;
        end
        else
        begin : g_reduce
            // Reciprocal with enough fraction bits to make the quotient exact.
            localparam int SHIFT = PAGE_IN_W + 2 * $clog2(PAGE_COUNT);
            localparam longint MULT_VAL =
                ((longint'(1) << SHIFT) + longint'(PAGE_COUNT) - 1) / PAGE_COUNT;
            localparam logic [SHIFT-1:0]       MULT   = SHIFT'(MULT_VAL);
            localparam logic [2*PAGE_IN_W-1:0] DIVISOR = (2*PAGE_IN_W)'(PAGE_COUNT);

            logic [PAGE_IN_W+SHIFT-1:0] prod;
            logic [PAGE_IN_W-1:0]       page_reg;
            logic [PAGE_IN_W-1:0]       quot_reg;
            logic [2*PAGE_IN_W-1:0]     back;
            logic [2*PAGE_IN_W-1:0]     diff;
            logic [2*PAGE_IN_W-1:0]     rem;
            logic [PW-1:0]              rem_reg;

            // Stage one: quotient estimate.
            assign prod = {{SHIFT{1'b0}}, in_page} * {{PAGE_IN_W{1'b0}}, MULT};

            always_ff @(posedge clk)
            begin
                page_reg <= in_page;
                quot_reg <= prod[PAGE_IN_W+SHIFT-1:SHIFT];
            end

            // Stage two: remainder with a single correction step.
            always_comb
            begin
                back = {{PAGE_IN_W{1'b0}}, quot_reg} * DIVISOR;
                diff = {{PAGE_IN_W{1'b0}}, page_reg} - back;
                rem  = (diff >= DIVISOR) ? (diff - DIVISOR) : diff;
            end

            always_ff @(posedge clk)
            begin
                rem_reg <= PW'(rem);
            end

            assign out_page = rem_reg;
        end
    endgenerate

endmodule

[sv/lru_cell.sv]
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame's page, valid mark and recency rank. A search word moves
// through the chain one cell per cycle; each cell folds in its own match,
// empty and victim candidates. An update command is applied at once to all
// active cells when a search completes.
// ----------------------------------------------------------------------------
module lru_cell
    import lru_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF,
    parameter int CELL_ID    = 0
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lru_cnt_w(NUM_FRAMES)-1:0]    active_count,
    // Search word from the previous cell.
    input  lru_link_t                           in_link,
    input  logic [lru_page_w(PAGE_COUNT)-1:0]   in_page,
    input  logic [lru_idx_w(NUM_FRAMES)-1:0]    in_hit_idx,
    input  logic [lru_idx_w(NUM_FRAMES)-1:0]    in_hit_rank,
    input  logic [lru_idx_w(NUM_FRAMES)-1:0]    in_empty_idx,
    input  logic [lru_idx_w(NUM_FRAMES)-1:0]    in_best_rank,
    input  logic [lru_idx_w(NUM_FRAMES)-1:0]    in_best_idx,
    input  logic [lru_page_w(PAGE_COUNT)-1:0]   in_best_page,
    // Search word to the next cell.
    output lru_link_t                           out_link,
    output logic [lru_page_w(PAGE_COUNT)-1:0]   out_page,
    output logic [lru_idx_w(NUM_FRAMES)-1:0]    out_hit_idx,
    output logic [lru_idx_w(NUM_FRAMES)-1:0]    out_hit_rank,
    output logic [lru_idx_w(NUM_FRAMES)-1:0]    out_empty_idx,
    output logic [lru_idx_w(NUM_FRAMES)-1:0]    out_best_rank,
    output logic [lru_idx_w(NUM_FRAMES)-1:0]    out_best_idx,
    output logic [lru_page_w(PAGE_COUNT)-1:0]   out_best_page,
    // Update command.
    input  lru_cmd_t                            cmd,
    input  logic [lru_idx_w(NUM_FRAMES)-1:0]    cmd_target,
    input  logic [lru_idx_w(NUM_FRAMES)-1:0]    cmd_limit,
    input  logic [lru_page_w(PAGE_COUNT)-1:0]   cmd_page
);

    localparam int IW = lru_idx_w(NUM_FRAMES);
    localparam int CW = lru_cnt_w(NUM_FRAMES);
    localparam int PW = lru_page_w(PAGE_COUNT);

    localparam logic [CW-1:0] CELL_POS  = CW'(CELL_ID);
    localparam logic [IW-1:0] CELL_IDX  = IW'(CELL_ID);
    localparam logic [IW-1:0] RANK_TOP  = IW'(NUM_FRAMES - 1);
    localparam bit            FIRST     = (CELL_ID == 0);

    // Frame state.
    logic          valid_reg;
    logic          valid_next;
    logic [IW-1:0] rank_reg;
    logic [IW-1:0] rank_next;
    logic [PW-1:0] page_reg;

    // Search word registers.
    lru_link_t     link_reg;
    lru_link_t     link_next;
    logic [PW-1:0] fwd_page_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [IW-1:0] hit_rank_reg;
    logic [IW-1:0] empty_idx_reg;
    logic [IW-1:0] best_rank_reg;
    logic [IW-1:0] best_idx_reg;
    logic [PW-1:0] best_page_reg;

    logic active;
    logic is_match;
    logic is_empty;
    logic take_best;
    logic is_target;
    logic write_page;

    assign active = (CELL_POS < active_count);

    // Candidates contributed by this frame.
    always_comb
    begin
        is_match  = active && valid_reg && (page_reg == in_page) && !in_link.hit_found;
        is_empty  = active && !valid_reg && !in_link.empty_found;
        take_best = active && (FIRST || (rank_reg > in_best_rank));

        link_next.valid       = in_link.valid;
        link_next.hit_found   = in_link.hit_found | is_match;
        link_next.empty_found = in_link.empty_found | is_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    // Search payload moves on only with a live word.
    always_ff @(posedge clk)
    begin
        if (in_link.valid)
        begin
            fwd_page_reg  <= in_page;
            hit_idx_reg   <= is_match ? CELL_IDX : in_hit_idx;
            hit_rank_reg  <= is_match ? rank_reg : in_hit_rank;
            empty_idx_reg <= is_empty ? CELL_IDX : in_empty_idx;
            best_rank_reg <= take_best ? rank_reg : in_best_rank;
            best_idx_reg  <= take_best ? CELL_IDX : in_best_idx;
            best_page_reg <= take_best ? page_reg : in_best_page;
        end
    end

    assign out_link      = link_reg;
    assign out_page      = fwd_page_reg;
    assign out_hit_idx   = hit_idx_reg;
    assign out_hit_rank  = hit_rank_reg;
    assign out_empty_idx = empty_idx_reg;
    assign out_best_rank = best_rank_reg;
    assign out_best_idx  = best_idx_reg;
    assign out_best_page = best_page_reg;

    // Recency update: the target becomes most recent, other valid frames age (all on a miss, younger ones on a hit).
    always_comb
    begin
        is_target  = (cmd_target == CELL_IDX);
        valid_next = valid_reg;
        rank_next  = rank_reg;
        write_page = 1'b0;
        if (cmd.valid && active)
        begin
            if (is_target)
            begin
                rank_next = '0;
                if (cmd.miss)
                begin
                    valid_next = 1'b1;
                    write_page = 1'b1;
                end
            end
            else if (valid_reg && (cmd.miss || (rank_reg < cmd_limit))
                     && (rank_reg != RANK_TOP))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // Resident page; read only while the frame is valid.
    always_ff @(posedge clk)
    begin
        if (write_page)
        begin
            page_reg <= cmd_page;
        end
    end

endmodule

[bench/tb_lru_page_replacement.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the LRU page replacement unit
// Sends page references through the start/busy command port and changes the
// frame count through the configuration channel between phases. A shadow
// copy of the frame table predicts every result word. Each word on the done
// strobe is compared field by field with the oldest prediction. A short
// table of directed rows comes first, then phases of random references with
// different sender idling.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement
    import lru_pkg::*;
();

    localparam int NFR         = NUM_FRAMES_DEF;
    localparam int LOOKUP_LAT  = NFR + 3;
    localparam int STALL_LIMIT = 1000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int POOL_SIZE   = 12;
    localparam int DIR_ROWS    = 28;

    // One result word of the block.
    typedef struct packed {
        logic                 hit;
        logic [FIDX_W-1:0]    frame;
        logic                 ev_valid;
        logic [PAGE_IN_W-1:0] ev_page;
        logic [FAULT_W-1:0]   faults;
    } lookup_t;

    typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

    // One row of the directed table: a reference or a frame count write.
    typedef struct packed {
        row_kind_t            kind;
        logic [PAGE_IN_W-1:0] value;
        logic                 typed;
        lookup_t              res;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [PAGE_IN_W-1:0] page_number = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 busy;
    logic                 done;
    logic                 hit;
    logic [FIDX_W-1:0]    frame_index;
    logic                 evicted_valid;
    logic [PAGE_IN_W-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_total;
    logic                 cfg_ready;

    // Shadow copy of the frame table and the frame count register.
    logic [PAGE_IN_W-1:0] shadow_page [NFR];
    logic                 shadow_valid [NFR];
    logic [FIDX_W-1:0]    shadow_rank [NFR];
    logic [FAULT_W-1:0]   shadow_faults;
    logic [CFG_W-1:0]     shadow_frames;

    lookup_t pending_lookups [$];
    int      fail_count = 0;
    int      sender_idle_pct = 0;
    int      stall_cycles = 0;

    // Percent of idle sender slots per phase, and the frame count per phase.
    int               idle_plan [4] = '{0, 66, 0, 19};
    logic [CFG_W-1:0] cfg_plan [NUM_PHASES] = '{4'd8, 4'd1, 4'd15, 4'd0,
                                                4'd4, 4'd2, 4'd9, 4'd7};

    // Directed rows: fill, eviction, frame count extremes, duplicate residents.
    stim_row_t dir_table [DIR_ROWS] = '{
        '{ROW_REF, 10'd0,    1'b1, '{1'b0, 3'd0, 1'b0, 10'd0,    32'd1}},
        '{ROW_REF, 10'd1023, 1'b1, '{1'b0, 3'd1, 1'b0, 10'd0,    32'd2}},
        '{ROW_REF, 10'd0,    1'b1, '{1'b1, 3'd0, 1'b0, 10'd0,    32'd2}},
        '{ROW_REF, 10'd5,    1'b0, '0},
        '{ROW_REF, 10'd10,   1'b0, '0},
        '{ROW_REF, 10'd20,   1'b0, '0},
        '{ROW_REF, 10'd40,   1'b0, '0},
        '{ROW_REF, 10'd80,   1'b0, '0},
        '{ROW_REF, 10'd160,  1'b0, '0},
        '{ROW_REF, 10'd512,  1'b1, '{1'b0, 3'd1, 1'b1, 10'd1023, 32'd9}},
        '{ROW_REF, 10'd5,    1'b0, '0},
        '{ROW_REF, 10'd341,  1'b0, '0},
        '{ROW_REF, 10'd682,  1'b0, '0},
        '{ROW_CFG, 10'd0,    1'b0, '0},
        '{ROW_REF, 10'd300,  1'b0, '0},
        '{ROW_REF, 10'd300,  1'b0, '0},
        '{ROW_CFG, 10'd15,   1'b0, '0},
        '{ROW_REF, 10'd300,  1'b0, '0},
        '{ROW_CFG, 10'd1,    1'b0, '0},
        '{ROW_REF, 10'd20,   1'b0, '0},
        '{ROW_CFG, 10'd8,    1'b0, '0},
        '{ROW_REF, 10'd20,   1'b0, '0},
        '{ROW_REF, 10'd999,  1'b0, '0},
        '{ROW_CFG, 10'd3,    1'b0, '0},
        '{ROW_REF, 10'd1,    1'b0, '0},
        '{ROW_REF, 10'd2,    1'b0, '0},
        '{ROW_REF, 10'd3,    1'b0, '0},
        '{ROW_REF, 10'd4,    1'b0, '0}
    };

    lru_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .done          (done),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Look up one page in the shadow table, update it and return the word.
    function automatic lookup_t predict_lookup(input logic [PAGE_IN_W-1:0] page);
        int      n;
        int      tgt;
        int      limit;
        int      best;
        bit      found_hit;
        bit      found_empty;
        lookup_t r;
        n = (shadow_frames == 0) ? 1 : ((shadow_frames > NFR) ? NFR : int'(shadow_frames));
        r = '0;
        tgt = 0;
        found_hit = 1'b0;
        found_empty = 1'b0;
        for (int f = 0; f < n; f++) begin
            if (!found_hit && shadow_valid[f] && shadow_page[f] == page) begin
                found_hit = 1'b1;
                tgt = f;
            end
        end
        if (found_hit) begin
            limit = shadow_rank[tgt];
        end
        else begin
            for (int f = 0; f < n; f++) begin
                if (!found_empty && !shadow_valid[f]) begin
                    found_empty = 1'b1;
                    tgt = f;
                end
            end
            // No empty frame: the oldest rank loses, lowest frame on a tie.
            if (!found_empty) begin
                best = 0;
                tgt = 0;
                for (int f = 0; f < n; f++) begin
                    if (shadow_rank[f] > best) begin
                        best = shadow_rank[f];
                        tgt = f;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page = shadow_page[tgt];
            end
            shadow_page[tgt] = page;
            shadow_valid[tgt] = 1'b1;
            limit = NFR;
            if (shadow_faults != '1)
                shadow_faults++;
        end
        // Age the younger valid frames, saturating at the oldest rank.
        for (int g = 0; g < n; g++) begin
            if (g != tgt && shadow_valid[g] && shadow_rank[g] < limit
                && shadow_rank[g] < NFR - 1)
                shadow_rank[g]++;
        end
        shadow_rank[tgt] = '0;
        r.hit = found_hit;
        r.frame = tgt[FIDX_W-1:0];
        r.faults = shadow_faults;
        return r;
    endfunction

    // Send one page reference, with an optional idle gap before it.
    task automatic send_ref(input logic [PAGE_IN_W-1:0] page, input bit typed,
                            input lookup_t typed_res);
        lookup_t predicted;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2 * LOOKUP_LAT)) @(posedge clk);
        end
        start <= 1'b1;
        page_number <= page;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_lookup(page);
        pending_lookups.push_back(typed ? typed_res : predicted);
    endtask

    // Write the frame count once every lookup in flight has reported.
    task automatic write_frames(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_frames = value;
        cfg_valid <= 1'b0;
    endtask

    // Compare each result word with the oldest prediction.
    always @(posedge clk) begin
        lookup_t want;
        if (rst_n && done) begin
            if (pending_lookups.size() == 0) begin
                $error("result word with nothing expected: frame_index %0d", frame_index);
                fail_count++;
            end
            else begin
                want = pending_lookups.pop_front();
                if (hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    fail_count++;
                end
                if (frame_index !== want.frame) begin
                    $error("frame_index: expected %0d, got %0d", want.frame, frame_index);
                    fail_count++;
                end
                if (evicted_valid !== want.ev_valid) begin
                    $error("evicted_valid: expected %0d, got %0d", want.ev_valid,
                           evicted_valid);
                    fail_count++;
                end
                if (evicted_page !== want.ev_page) begin
                    $error("evicted_page: expected %0d, got %0d", want.ev_page,
                           evicted_page);
                    fail_count++;
                end
                if (fault_total !== want.faults) begin
                    $error("fault_total: expected %0d, got %0d", want.faults, fault_total);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        logic [PAGE_IN_W-1:0] pool [POOL_SIZE];
        logic [PAGE_IN_W-1:0] pg;
        int                   pick;
        for (int f = 0; f < NFR; f++) begin
            shadow_page[f] = '0;
            shadow_valid[f] = 1'b0;
            shadow_rank[f] = '0;
        end
        shadow_faults = '0;
        shadow_frames = CFG_FRAMES_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG)
                write_frames(dir_table[i].value[CFG_W-1:0]);
            else
                send_ref(dir_table[i].value, dir_table[i].typed, dir_table[i].res);
        end

        // Mostly references to a small page pool so hits and evictions mix.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            sender_idle_pct = idle_plan[phase % 4];
            write_frames(cfg_plan[phase]);
            foreach (pool[k])
                pool[k] = PAGE_IN_W'($urandom_range(PAGE_COUNT_DEF - 1));
            for (int item = 0; item < PHASE_ITEMS; item++) begin
                pick = $urandom_range(99);
                if (pick < 75)
                    pg = pool[$urandom_range(POOL_SIZE - 1)];
                else if (pick < 80)
                    pg = pick[0] ? '1 : '0;
                else
                    pg = PAGE_IN_W'($urandom_range(PAGE_COUNT_DEF - 1));
                send_ref(pg, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (LOOKUP_LAT + 2) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
